// ===== rtl/core/quaternion_ekf_predict_unit_defines.svh =====
// Assertion macros shared by the quaternion predictor RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef QUATERNION_EKF_PREDICT_UNIT_DEFINES_SVH
`define QUATERNION_EKF_PREDICT_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define QEP_ASSERT_IMPL(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define QEP_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define QEP_ASSERT_IMPL(lbl, clk, rstn, a, c)
`define QEP_ASSERT_NEXT(lbl, clk, rstn, a, c)
`endif
`endif

// ===== rtl/core/qep_pkg.sv =====
// Package for the quaternion predictor: formats, register codes, types.
// Used by every module of the block.
package qep_pkg;
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_TIME_STEP = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NOISE_W   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NOISE_X   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_NOISE_Y   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_NOISE_Z   = 3'd4;
    localparam logic signed [31:0] ONE_Q24 = 32'sh0100_0000;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    typedef enum logic [2:0] {
        ST_IDLE, ST_HALF, ST_QUAT, ST_AP, ST_APAT, ST_DONE
    } ctrl_state_t;

    // Saturate a wide sum into 32 signed bits.
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = 40'sh00_7FFF_FFFF;
        lo = -40'sh00_8000_0000;
        if (v > hi) sat32 = 32'sh7FFF_FFFF;
        else if (v < lo) sat32 = 32'sh8000_0000;
        else sat32 = v[31:0];
    endfunction

    // Entry (r,c) of the transition matrix from the three half angles.
    function automatic logic signed [31:0] a_entry(
        input logic [1:0] r, input logic [1:0] c,
        input logic signed [31:0] hx, input logic signed [31:0] hy,
        input logic signed [31:0] hz);
        logic [3:0] rc;
        rc = {r, c};
        case (rc)
            4'h0, 4'h5, 4'hA, 4'hF: a_entry = ONE_Q24;
            4'h1, 4'hE: a_entry = -hx;
            4'h2, 4'h7: a_entry = -hy;
            4'h3, 4'h9: a_entry = -hz;
            4'h4, 4'hB: a_entry = hx;
            4'h8, 4'hD: a_entry = hy;
            4'h6, 4'hC: a_entry = hz;
            default: a_entry = ONE_Q24;
        endcase
    endfunction
endpackage

// ===== rtl/core/qep_mac.sv =====
// Shared multiply, round and accumulate unit for the predictor.
// Depends on qep_pkg; one product per cycle, registered after the multiply.
module qep_mac (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                clr,
    input  logic                en,
    input  logic signed [31:0]  op_a,
    input  logic signed [31:0]  op_b,
    output logic signed [39:0]  acc
);
    import qep_pkg::*;

    logic signed [63:0] prod_reg;
    logic               pv_reg;
    logic               first_reg;
    logic signed [39:0] acc_reg;
    logic signed [63:0] rnd;

    // Multiply stage; clr marks the first product of a dot product.
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (!aresetn) begin
            pv_reg <= 1'b0;
            first_reg <= 1'b0;
        end else begin
            pv_reg <= en;
            first_reg <= en && clr;
        end
    end

    // Round off the 24 fraction bits of a Q24 op_a from each product and accumulate exactly.
    assign rnd = (prod_reg + 64'sd8388608) >>> 24;
    always_ff @(posedge aclk) begin
        if (!aresetn) acc_reg <= '0;
        else if (pv_reg) acc_reg <= first_reg ? rnd[39:0] : acc_reg + rnd[39:0];
    end
    assign acc = acc_reg;
endmodule

// ===== rtl/core/qep_ctrl.sv =====
// Sequencer: walks the quaternion, A*P and A*P*A^T passes over the stores.
// Depends on qep_pkg, qep_mac and the defines header; holds quaternion and covariance memories.
`include "quaternion_ekf_predict_unit_defines.svh"
module qep_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [31:0]  rx,
    input  logic signed [31:0]  ry,
    input  logic signed [31:0]  rz,
    input  logic [31:0]         dt,
    input  logic [30:0]         nz0,
    input  logic [30:0]         nz1,
    input  logic [30:0]         nz2,
    input  logic [30:0]         nz3,
    output logic                busy,
    output logic                done,
    output logic [255:0]        result
);
    import qep_pkg::*;

    ctrl_state_t state_reg, state_next;
    // Step counter: bits [1:0] k, then j, then i, then the drain steps of each pass.
    logic [6:0] cnt_reg, cnt_next;
    logic signed [31:0] hx_reg, hy_reg, hz_reg;
    logic [1:0] hcnt_reg;
    logic signed [31:0] quat_mem [4];
    logic signed [31:0] cov_mem [16];
    logic signed [31:0] ap_mem [16];
    logic signed [31:0] qrd_reg, crd_reg, aprd_reg;
    logic signed [31:0] nq_reg [4];
    logic signed [31:0] diag_reg [4];
    logic [1:0] ii, jj, kk;
    logic [1:0] ii_d, jj_d;
    logic       last_d;
    logic       mac_en;
    logic signed [31:0] mop_a, mop_b;
    logic signed [39:0] acc;
    logic signed [63:0] hp;
    logic signed [31:0] rsel;
    logic [1:0] hidx_reg;
    logic       fin;
    logic signed [31:0] ssum;
    logic signed [31:0] cov_wr;
    logic [30:0] nsel;
    logic signed [31:0] ad_reg;
    logic       en_d, clr_d;
    logic [5:0] idx_p1, idx_p2, idx_p3;
    logic       lastk_p1, lastk_p2, lastk_p3;

    assign kk = cnt_reg[1:0];
    assign jj = cnt_reg[3:2];
    assign ii = cnt_reg[5:4];
    assign busy = (state_reg != ST_IDLE);

    // Next state.
    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_IDLE: if (start) begin state_next = ST_HALF; cnt_next = '0; end
            ST_HALF: if (cnt_reg == 7'd3) begin state_next = ST_QUAT; cnt_next = '0; end
                     else cnt_next = cnt_reg + 7'd1;
            ST_QUAT: if (fin) begin state_next = ST_AP; cnt_next = '0; end
                     else cnt_next = cnt_reg + 7'd1;
            ST_AP:   if (fin) begin state_next = ST_APAT; cnt_next = '0; end
                     else cnt_next = cnt_reg + 7'd1;
            ST_APAT: if (fin) begin state_next = ST_DONE; cnt_next = '0; end
                     else cnt_next = cnt_reg + 7'd1;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Pass ends when all steps are issued and the last sum is written.
    always_comb begin
        fin = 1'b0;
        case (state_reg)
            ST_QUAT: fin = (cnt_reg == 7'd18);
            ST_AP, ST_APAT: fin = (cnt_reg == 7'd66);
            default: fin = 1'b0;
        endcase
    end

    // Outputs: issue one product per cycle while steps remain.
    always_comb begin
        mac_en = 1'b0;
        case (state_reg)
            ST_QUAT: mac_en = (cnt_reg < 7'd16);
            ST_AP, ST_APAT: mac_en = (cnt_reg < 7'd64);
            default: mac_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    // Half-angle terms, one rate per cycle.
    always_comb begin
        case (cnt_reg[1:0])
            2'd0: rsel = rx;
            2'd1: rsel = ry;
            default: rsel = rz;
        endcase
    end
    always_ff @(posedge aclk) begin
        hp <= $signed({1'b0, dt}) * rsel;
        hidx_reg <= cnt_reg[1:0];
        hcnt_reg <= (state_reg == ST_HALF) ? 2'd1 : 2'd0;
        if (hcnt_reg == 2'd1) begin
            case (hidx_reg)
                2'd0: hx_reg <= 32'((hp + 64'sh1_0000_0000) >>> 33);
                2'd1: hy_reg <= 32'((hp + 64'sh1_0000_0000) >>> 33);
                2'd2: hz_reg <= 32'((hp + 64'sh1_0000_0000) >>> 33);
                default: ;
            endcase
        end
    end

    // Registered memory reads; the quaternion pass reads
    // q[k], A*P reads P[k][j], the second pass reads AP[i][k].
    always_ff @(posedge aclk) begin
        qrd_reg  <= quat_mem[kk];
        crd_reg  <= cov_mem[{kk, jj}];
        aprd_reg <= ap_mem[{ii, kk}];
    end

    // A operand delayed to line up with the read data.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_QUAT: ad_reg <= a_entry(jj, kk, hx_reg, hy_reg, hz_reg);
            ST_AP:   ad_reg <= a_entry(ii, kk, hx_reg, hy_reg, hz_reg);
            default: ad_reg <= a_entry(jj, kk, hx_reg, hy_reg, hz_reg);
        endcase
        if (!aresetn) en_d <= 1'b0;
        else en_d <= mac_en;
        clr_d <= mac_en && (kk == 2'd0);
    end
    assign mop_a = ad_reg;
    assign mop_b = (state_reg == ST_QUAT) ? qrd_reg :
                   (state_reg == ST_AP) ? crd_reg : aprd_reg;

    // The accumulator restarts on the first product of each dot product.
    qep_mac u_mac (
        .aclk(aclk), .aresetn(aresetn), .clr(clr_d),
        .en(en_d), .op_a(mop_a), .op_b(mop_b), .acc(acc)
    );

    // Index pipeline: idx_p1, idx_p2, idx_p3 follow each product past the read, multiply and sum registers.
    always_ff @(posedge aclk) begin
        idx_p1 <= cnt_reg[5:0];
        idx_p2 <= idx_p1;
        idx_p3 <= idx_p2;
        if (!aresetn) begin
            lastk_p1 <= 1'b0;
            lastk_p2 <= 1'b0;
            lastk_p3 <= 1'b0;
        end else begin
            lastk_p1 <= mac_en && (kk == 2'd3);
            lastk_p2 <= lastk_p1;
            lastk_p3 <= lastk_p2;
        end
    end
    assign ii_d = idx_p3[5:4];
    assign jj_d = idx_p3[3:2];
    assign last_d = lastk_p3;
    assign ssum = sat32(acc);
    assign cov_wr = (ii_d == jj_d) ? sat32(40'(ssum) + $signed({9'd0, nsel})) : ssum;

    // Write back finished dot products.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_mem[0] <= ONE_Q30;
            quat_mem[1] <= '0; quat_mem[2] <= '0; quat_mem[3] <= '0;
            for (int n = 0; n < 16; n++) cov_mem[n] <= '0;
        end else if (last_d) begin
            case (state_reg)
                ST_QUAT: nq_reg[jj_d] <= ssum;
                ST_AP:   ap_mem[{ii_d, jj_d}] <= ssum;
                ST_APAT: cov_mem[{ii_d, jj_d}] <= cov_wr;
                default: ;
            endcase
        end else if (state_reg == ST_AP && cnt_reg == 7'd0) begin
            for (int n = 0; n < 4; n++) quat_mem[n] <= nq_reg[n];
        end
    end
    always_comb begin
        case (ii_d)
            2'd0: nsel = nz0;
            2'd1: nsel = nz1;
            2'd2: nsel = nz2;
            default: nsel = nz3;
        endcase
    end

    // Keep a copy of the new covariance diagonal for the result item.
    always_ff @(posedge aclk) begin
        if (last_d && state_reg == ST_APAT && ii_d == jj_d) diag_reg[ii_d] <= cov_wr;
    end

    // Result captured when the last pass is finished.
    always_ff @(posedge aclk) begin
        if (!aresetn) done <= 1'b0;
        else done <= (state_reg == ST_DONE);
    end
    assign result = {diag_reg[3], diag_reg[2], diag_reg[1], diag_reg[0],
                     nq_reg[3], nq_reg[2], nq_reg[1], nq_reg[0]};

    `QEP_ASSERT_NEXT(a_start_leaves_idle, aclk, aresetn,
        state_reg == ST_IDLE && start, state_reg == ST_HALF)
    `QEP_ASSERT_IMPL(a_no_write_idle, aclk, aresetn,
        state_reg == ST_IDLE, !last_d)
    `QEP_ASSERT_NEXT(a_done_pulse, aclk, aresetn, done, !done)
endmodule

// ===== rtl/core/quaternion_ekf_predict_unit.sv =====
// Top level of the quaternion EKF prediction block.
// Depends on qep_pkg and qep_ctrl; holds config registers and the result register.
//
// Use: write time_step (index 0) and noise_w..noise_z (1..4) on the cfg channel
// while idle. Each s_ item carries one gyro sample (rate_x, rate_y, rate_z).
// The block replies with one m_ item: the new quaternion and the covariance
// diagonal. Once the input item is accepted, the block starts and forms the
// half angles, then the shared multiply-accumulate unit does 16 quaternion
// steps and 2x64 covariance steps, one per cycle, each pass followed by drain
// steps, and the block finishes and registers the result. One item is in
// work at a time. A new item is taken while the previous result waits in the
// output register, but its work does not start until that result is taken,
// so a stalled receiver stalls the input.
// Reset (aresetn low, synchronous) sets the quaternion to (1,0,0,0), the
// covariance and the config registers to zero, and empties the output.
module quaternion_ekf_predict_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [qep_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,   // rate_x, rate_y, rate_z
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [255:0]  m_tdata    // quat_w,x,y,z, cov_00,11,22,33
);
    import qep_pkg::*;

    logic [31:0] time_step_reg;
    logic [30:0] noise_w_reg, noise_x_reg, noise_y_reg, noise_z_reg;
    logic [95:0] in_reg;
    logic        pend_reg;
    logic        busy, done, start;
    logic [255:0] result;
    logic        mv_reg;
    logic [255:0] md_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= '0;
            noise_w_reg <= '0; noise_x_reg <= '0;
            noise_y_reg <= '0; noise_z_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TIME_STEP: time_step_reg <= cfg_data;
                REG_NOISE_W:   noise_w_reg <= cfg_data[30:0];
                REG_NOISE_X:   noise_x_reg <= cfg_data[30:0];
                REG_NOISE_Y:   noise_y_reg <= cfg_data[30:0];
                REG_NOISE_Z:   noise_z_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Input holding register; work starts once the output is free.
    assign s_tready = !pend_reg && !busy;
    assign start = pend_reg && !busy && !mv_reg;
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) in_reg <= s_tdata;
        if (!aresetn) pend_reg <= 1'b0;
        else if (s_tvalid && s_tready) pend_reg <= 1'b1;
        else if (start) pend_reg <= 1'b0;
    end

    qep_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .start(start),
        .rx(in_reg[31:0]), .ry(in_reg[63:32]), .rz(in_reg[95:64]),
        .dt(time_step_reg), .nz0(noise_w_reg), .nz1(noise_x_reg),
        .nz2(noise_y_reg), .nz3(noise_z_reg),
        .busy(busy), .done(done), .result(result)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (done) md_reg <= result;
        if (!aresetn) mv_reg <= 1'b0;
        else if (done) mv_reg <= 1'b1;
        else if (m_tready) mv_reg <= 1'b0;
    end
    assign m_tvalid = mv_reg;
    assign m_tdata = md_reg;
endmodule
